>>> rtl/ttvc_pkg.sv
`default_nettype none
package ttvc_pkg;

	localparam int VAL_W = 48;
	localparam int ATAN_IW = 5;
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 32;

	typedef logic signed [VAL_W-1:0] val_t;

	localparam logic [CFG_IW-1:0] CFG_GAIN_K     = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_VXY_LIMIT  = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_VZ_LIMIT   = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_WZ_LIMIT   = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_TAKEOFF    = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_PHASE_STEP = 3'd5;
	localparam logic [CFG_IW-1:0] CFG_ANG_RATE   = 3'd6;

	localparam logic [1:0] PH_TAKEOFF = 2'd0;
	localparam logic [1:0] PH_TRACK   = 2'd1;
	localparam logic [1:0] PH_LAND    = 2'd2;
	localparam logic [1:0] PH_STOP    = 2'd3;

	typedef enum logic [1:0] {
		K_TAKEOFF = 2'd0,
		K_TRACK   = 2'd1,
		K_LAND    = 2'd2,
		K_STOP    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CS_REF = 2'd0,
		CS_DBL = 2'd1,
		CS_HDG = 2'd2
	} csel_t;

	typedef enum logic [4:0] {
		OP_HD  = 5'd0,
		OP_XS  = 5'd1,
		OP_YS  = 5'd2,
		OP_ZS  = 5'd3,
		OP_WS  = 5'd4,
		OP_AW  = 5'd5,
		OP_AWC = 5'd6,
		OP_KEX = 5'd7,
		OP_BW  = 5'd8,
		OP_BWC = 5'd9,
		OP_KEY = 5'd10,
		OP_CW  = 5'd11,
		OP_CWC = 5'd12,
		OP_KEZ = 5'd13,
		OP_DW  = 5'd14,
		OP_DWC = 5'd15,
		OP_KEW = 5'd16,
		OP_UXC = 5'd17,
		OP_UYS = 5'd18,
		OP_UYC = 5'd19,
		OP_UXS = 5'd20
	} op_t;

	typedef struct packed {
		logic       load;
		logic       clr_phase;
		logic       adv_phase;
		logic       mul_go;
		op_t        op;
		logic       cord_go;
		csel_t      csel;
		logic       emit;
		kind_t      kind;
		logic [1:0] phase;
	} cmd_t;

	typedef struct packed {
		logic ge_toff;
		logic lt_slow;
		logic land;
		logic cord_done;
		logic out_free;
	} status_t;

	function automatic logic [31:0] atan_f(input logic [ATAN_IW-1:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/ttvc_meas_if.sv
`default_nettype none
interface ttvc_meas_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic signed [23:0] pos_z;
	logic signed [18:0] heading;
	logic               land_request;

	modport source (output valid, pos_x, pos_y, pos_z, heading, land_request, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, heading, land_request, output ready);
endinterface
`default_nettype wire

>>> rtl/ttvc_cmd_if.sv
`default_nettype none
interface ttvc_cmd_if;
	logic               valid;
	logic               ready;
	logic signed [18:0] vel_x;
	logic signed [18:0] vel_y;
	logic signed [18:0] vel_z;
	logic signed [19:0] yaw_rate;
	logic [1:0]         flight_phase;
	logic signed [23:0] err_x;
	logic signed [23:0] err_y;
	logic signed [23:0] err_z;
	logic signed [19:0] err_yaw;

	modport source (output valid, vel_x, vel_y, vel_z, yaw_rate, flight_phase,
		err_x, err_y, err_z, err_yaw, input ready);
	modport sink (input valid, vel_x, vel_y, vel_z, yaw_rate, flight_phase,
		err_x, err_y, err_z, err_yaw, output ready);
endinterface
`default_nettype wire

>>> rtl/ttvc_cordic.sv
`default_nettype none
module ttvc_cordic #(
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 18
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [31:0]    angle,
	output ttvc_pkg::val_t      cos_v,
	output ttvc_pkg::val_t      sin_v,
	output logic                done
);
	import ttvc_pkg::*;

	localparam logic [ATAN_IW-1:0] LAST = ATAN_IW'(CORDIC_STEPS - 1);
	localparam val_t RND = val_t'(64'sd1 <<< (29 - FRAC_BITS));

	logic signed [33:0] x_q, y_q, z_q;
	logic signed [33:0] xs, ys, at;
	logic [ATAN_IW-1:0] cnt_q;
	logic               busy_q, done_q, neg_q, flip;
	logic [31:0]        a2;
	val_t               xv, yv;

	assign flip = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
	assign a2   = flip ? {~angle[31], angle[30:0]} : angle;
	assign xs   = x_q >>> cnt_q;
	assign ys   = y_q >>> cnt_q;
	assign at   = $signed({2'b00, atan_f(cnt_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= 34'sd652032874;
			y_q   <= '0;
			z_q   <= {{2{a2[31]}}, a2};
			neg_q <= flip;
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign xv    = neg_q ? -val_t'(x_q) : val_t'(x_q);
	assign yv    = neg_q ? -val_t'(y_q) : val_t'(y_q);
	assign cos_v = (xv + RND) >>> (30 - FRAC_BITS);
	assign sin_v = (yv + RND) >>> (30 - FRAC_BITS);
	assign done  = done_q;

endmodule
`default_nettype wire

>>> rtl/ttvc_dp.sv
`default_nettype none
module ttvc_dp #(
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 18
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_idx,
	input  wire logic [31:0]        cfg_wdata,
	input  ttvc_pkg::cmd_t          cmd,
	output ttvc_pkg::status_t       status,
	input  wire logic signed [23:0] pos_x,
	input  wire logic signed [23:0] pos_y,
	input  wire logic signed [23:0] pos_z,
	input  wire logic signed [18:0] heading,
	input  wire logic               land_request,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output logic signed [18:0]      vel_x,
	output logic signed [18:0]      vel_y,
	output logic signed [18:0]      vel_z,
	output logic signed [19:0]      yaw_rate,
	output logic [1:0]              flight_phase,
	output logic signed [23:0]      err_x,
	output logic signed [23:0]      err_y,
	output logic signed [23:0]      err_z,
	output logic signed [19:0]      err_yaw
);
	import ttvc_pkg::*;

	localparam val_t ONE  = val_t'(64'sd1 <<< FRAC_BITS);
	localparam val_t KA   = 3 * ONE;
	localparam val_t KB   = 3 * (ONE / 2);
	localparam val_t KB2  = 2 * KB;
	localparam val_t KY0  = -(ONE / 2);
	localparam val_t KZ0  = 3 * (ONE / 2);
	localparam val_t KC   = ONE / 2;
	localparam val_t KD   = (val_t'(64'sd1686629713) + val_t'(64'sd1 <<< (29 - FRAC_BITS)))
		>>> (30 - FRAC_BITS);
	localparam val_t SLOW = (ONE + 2) / 5;
	localparam val_t HDK  = val_t'(64'sd683565276);
	localparam val_t P24  = val_t'(64'sd8388607);
	localparam val_t N24  = val_t'(-64'sd8388608);
	localparam val_t P20  = val_t'(64'sd524287);

	function automatic val_t sat_f(input val_t v, input val_t lo, input val_t hi);
		val_t r;
		if (v < lo) r = lo;
		else if (v > hi) r = hi;
		else r = v;
		return r;
	endfunction

	function automatic val_t clamp_f(input val_t v, input val_t l);
		val_t r;
		if (v > l) r = l;
		else if (v < -l) r = -l;
		else r = v;
		return r;
	endfunction

	logic [17:0] gain_q, vxy_q, vz_lim_q;
	logic [18:0] wz_lim_q, rate_q;
	logic [19:0] toff_q;
	logic [31:0] step_q, ref_phase_q, hb_q, cang;

	logic signed [23:0] px_q, py_q, pz_q;
	logic signed [18:0] hd_q;
	logic               land_q;

	val_t c1_q, s1_q, c2_q, s2_q, cy_q, sy_q;
	val_t ex_q, ey_q, ez_q, ew_q, tmp_q, acc_q, ux_q, uy_q, vx_q, vy_q, vz_q, wz_q;
	val_t ma, mb, prod_s1, cos_v, sin_v, t;
	val_t cvx, cvy, cvz, cwz;
	logic signed [63:0] prod, prod_sh;
	op_t   op_s1;
	logic  wb_s1, cdone, ov_q;
	csel_t csel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= 18'd26214;
			vxy_q    <= 18'd98304;
			vz_lim_q <= 18'd32768;
			wz_lim_q <= 19'd262144;
			toff_q   <= 20'd78643;
			step_q   <= 32'd858993;
			rate_q   <= 19'd4118;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_GAIN_K:     gain_q   <= cfg_wdata[17:0];
				CFG_VXY_LIMIT:  vxy_q    <= cfg_wdata[17:0];
				CFG_VZ_LIMIT:   vz_lim_q <= cfg_wdata[17:0];
				CFG_WZ_LIMIT:   wz_lim_q <= cfg_wdata[18:0];
				CFG_TAKEOFF:    toff_q   <= cfg_wdata[19:0];
				CFG_PHASE_STEP: step_q   <= cfg_wdata;
				CFG_ANG_RATE:   rate_q   <= cfg_wdata[18:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q   <= pos_x;
			py_q   <= pos_y;
			pz_q   <= pos_z;
			hd_q   <= heading;
			land_q <= land_request;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_phase_q <= '0;
		end else if (cmd.clr_phase) begin
			ref_phase_q <= '0;
		end else if (cmd.adv_phase) begin
			ref_phase_q <= ref_phase_q + step_q;
		end
	end

	always_comb begin
		unique case (cmd.csel)
			CS_REF:  cang = ref_phase_q;
			CS_DBL:  cang = {ref_phase_q[30:0], 1'b0};
			CS_HDG:  cang = hb_q;
			default: cang = ref_phase_q;
		endcase
	end

	ttvc_cordic #(
		.FRAC_BITS   (FRAC_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.cord_go),
		.angle (cang),
		.cos_v (cos_v),
		.sin_v (sin_v),
		.done  (cdone)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csel_q <= CS_REF;
		end else if (cmd.cord_go) begin
			csel_q <= cmd.csel;
		end
	end

	always_ff @(posedge clk) begin
		if (cdone) begin
			unique case (csel_q)
				CS_REF: begin
					c1_q <= cos_v;
					s1_q <= sin_v;
				end
				CS_DBL: begin
					c2_q <= cos_v;
					s2_q <= sin_v;
				end
				CS_HDG: begin
					cy_q <= cos_v;
					sy_q <= sin_v;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cmd.op)
			OP_HD:  begin ma = val_t'(hd_q);   mb = HDK;              end
			OP_XS:  begin ma = KA;             mb = s1_q;             end
			OP_YS:  begin ma = KB;             mb = s2_q;             end
			OP_ZS:  begin ma = KC;             mb = s1_q;             end
			OP_WS:  begin ma = KD;             mb = s1_q;             end
			OP_AW:  begin ma = KA;             mb = val_t'(rate_q);   end
			OP_AWC: begin ma = tmp_q;          mb = c1_q;             end
			OP_KEX: begin ma = val_t'(gain_q); mb = ex_q;             end
			OP_BW:  begin ma = KB2;            mb = val_t'(rate_q);   end
			OP_BWC: begin ma = tmp_q;          mb = c2_q;             end
			OP_KEY: begin ma = val_t'(gain_q); mb = ey_q;             end
			OP_CW:  begin ma = KC;             mb = val_t'(rate_q);   end
			OP_CWC: begin ma = tmp_q;          mb = c1_q;             end
			OP_KEZ: begin ma = val_t'(gain_q); mb = ez_q;             end
			OP_DW:  begin ma = KD;             mb = val_t'(rate_q);   end
			OP_DWC: begin ma = tmp_q;          mb = c1_q;             end
			OP_KEW: begin ma = val_t'(gain_q); mb = ew_q;             end
			OP_UXC: begin ma = ux_q;           mb = cy_q;             end
			OP_UYS: begin ma = uy_q;           mb = sy_q;             end
			OP_UYC: begin ma = uy_q;           mb = cy_q;             end
			OP_UXS: begin ma = ux_q;           mb = sy_q;             end
			default: begin ma = '0;            mb = '0;               end
		endcase
	end

	assign prod    = $signed(ma[31:0]) * $signed(mb[31:0]);
	assign prod_sh = prod >>> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_s1 <= 1'b0;
		end else begin
			wb_s1 <= cmd.mul_go;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			prod_s1 <= prod_sh[VAL_W-1:0];
			op_s1   <= cmd.op;
		end
	end

	assign t = prod_s1;

	always_ff @(posedge clk) begin
		if (wb_s1) begin
			unique case (op_s1)
				OP_HD:  hb_q  <= t[31:0];
				OP_XS:  ex_q  <= sat_f(val_t'(px_q) - t, N24, P24);
				OP_YS:  ey_q  <= sat_f(val_t'(py_q) - (KY0 + t), N24, P24);
				OP_ZS:  ez_q  <= sat_f(val_t'(pz_q) - (KZ0 + t), N24, P24);
				OP_WS:  ew_q  <= sat_f(val_t'(hd_q) - t, -P20, P20);
				OP_AW, OP_BW, OP_CW, OP_DW: tmp_q <= t;
				OP_AWC, OP_BWC, OP_CWC, OP_DWC, OP_UXC, OP_UYC: acc_q <= t;
				OP_KEX: ux_q  <= acc_q - t;
				OP_KEY: uy_q  <= acc_q - t;
				OP_KEZ: vz_q  <= acc_q - t;
				OP_KEW: wz_q  <= acc_q - t;
				OP_UYS: vx_q  <= acc_q + t;
				OP_UXS: vy_q  <= acc_q - t;
				default: ;
			endcase
		end
	end

	assign cvx = clamp_f(vx_q, val_t'(vxy_q));
	assign cvy = clamp_f(vy_q, val_t'(vxy_q));
	assign cvz = clamp_f(vz_q, val_t'(vz_lim_q));
	assign cwz = clamp_f(wz_q, val_t'(wz_lim_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			flight_phase <= cmd.phase;
			vel_x        <= '0;
			vel_y        <= '0;
			vel_z        <= '0;
			yaw_rate     <= '0;
			err_x        <= '0;
			err_y        <= '0;
			err_z        <= '0;
			err_yaw      <= '0;
			unique case (cmd.kind)
				K_TAKEOFF: vel_z <= SLOW[18:0];
				K_LAND:    vel_z <= -SLOW[18:0];
				K_TRACK: begin
					vel_x    <= cvx[18:0];
					vel_y    <= cvy[18:0];
					vel_z    <= cvz[18:0];
					yaw_rate <= cwz[19:0];
					err_x    <= ex_q[23:0];
					err_y    <= ey_q[23:0];
					err_z    <= ez_q[23:0];
					err_yaw  <= ew_q[19:0];
				end
				K_STOP: ;
				default: ;
			endcase
		end
	end

	assign out_valid        = ov_q;
	assign status.ge_toff   = val_t'(pz_q) >= val_t'(toff_q);
	assign status.lt_slow   = val_t'(pz_q) < SLOW;
	assign status.land      = land_q;
	assign status.cord_done = cdone;
	assign status.out_free  = !ov_q || out_ready;

endmodule
`default_nettype wire

>>> rtl/ttvc_ctrl.sv
`default_nettype none
module ttvc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  ttvc_pkg::status_t  status,
	output ttvc_pkg::cmd_t     cmd
);
	import ttvc_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECIDE = 8'b0000_0010,
		S_HD     = 8'b0000_0100,
		S_HDW    = 8'b0000_1000,
		S_CORD   = 8'b0001_0000,
		S_MUL    = 8'b0010_0000,
		S_MULW   = 8'b0100_0000,
		S_FIN    = 8'b1000_0000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] pst_q, pst_d;
	logic       land_q, land_d;
	kind_t      kind_q, kind_d;
	op_t        op_q, op_d;
	csel_t      csel_q, csel_d;
	logic       clr_d;

	always_comb begin
		land_d = land_q | (status.land && pst_q != PH_STOP);
		clr_d  = 1'b0;
		kind_d = K_STOP;
		pst_d  = pst_q;
		unique case (pst_q)
			PH_TAKEOFF: begin
				if (status.ge_toff) begin
					kind_d = K_TRACK;
					pst_d  = PH_TRACK;
					clr_d  = 1'b1;
				end else begin
					kind_d = K_TAKEOFF;
				end
			end
			PH_TRACK: kind_d = K_TRACK;
			PH_LAND: begin
				kind_d = K_LAND;
				if (status.lt_slow) pst_d = PH_STOP;
			end
			default: kind_d = K_STOP;
		endcase
		if (land_d && pst_d != PH_STOP) pst_d = PH_LAND;
	end

	always_comb begin
		state_d       = state_q;
		op_d          = op_q;
		csel_d        = csel_q;
		cmd           = '0;
		cmd.op        = op_q;
		cmd.csel      = csel_q;
		cmd.kind      = kind_q;
		cmd.phase     = pst_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.clr_phase = clr_d;
				state_d       = (kind_d == K_TRACK) ? S_HD : S_FIN;
			end
			S_HD: begin
				cmd.mul_go = 1'b1;
				cmd.op     = OP_HD;
				state_d    = S_HDW;
			end
			S_HDW: begin
				cmd.cord_go = 1'b1;
				cmd.csel    = CS_REF;
				csel_d      = CS_REF;
				state_d     = S_CORD;
			end
			S_CORD: begin
				if (status.cord_done) begin
					if (csel_q == CS_HDG) begin
						op_d    = OP_XS;
						state_d = S_MUL;
					end else begin
						csel_d      = (csel_q == CS_REF) ? CS_DBL : CS_HDG;
						cmd.csel    = csel_d;
						cmd.cord_go = 1'b1;
					end
				end
			end
			S_MUL: begin
				cmd.mul_go = 1'b1;
				state_d    = S_MULW;
			end
			S_MULW: begin
				if (op_q == OP_UXS) begin
					state_d = S_FIN;
				end else begin
					op_d    = op_t'(op_q + 5'd1);
					state_d = S_MUL;
				end
			end
			S_FIN: begin
				if (status.out_free) begin
					cmd.emit      = 1'b1;
					cmd.adv_phase = (kind_q == K_TRACK);
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pst_q   <= PH_TAKEOFF;
			land_q  <= 1'b0;
			kind_q  <= K_TAKEOFF;
			op_q    <= OP_HD;
			csel_q  <= CS_REF;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			csel_q  <= csel_d;
			if (state_q == S_DECIDE) begin
				pst_q  <= pst_d;
				land_q <= land_d;
				kind_q <= kind_d;
			end
		end
	end

	assign in_ready = (state_q == S_IDLE);

`ifndef SYNTHESIS
	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DECIDE))
		else $error("accepted tick did not move to decide");
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(pst_q == PH_STOP) |=> (pst_q == PH_STOP))
		else $error("stopped phase left");
	a_takeoff_exit: assert property (@(posedge clk) disable iff (!arst_n)
		($past(pst_q) == PH_TAKEOFF && pst_q != PH_TAKEOFF)
		|-> (pst_q == PH_TRACK || pst_q == PH_LAND))
		else $error("takeoff left to a bad phase");
	a_emit_track: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.adv_phase |-> (cmd.emit && kind_q == K_TRACK))
		else $error("reference phase advanced outside a tracking result");
`endif

endmodule
`default_nettype wire

>>> rtl/trajectory_tracking_velocity_controller.sv
// Velocity controller for one drone: each accepted tick on meas yields exactly one command on
// ctl. Takeoff, landing and stopped ticks skip the arithmetic; a tracking tick is set by one
// iterative CORDIC run three times (reference phase, doubled phase, heading) and one shared
// 32x32 multiplier issuing the 21 products of the control law one after another. A new tick
// is taken as soon as the previous one has been placed in the output register, even while
// that result is still waiting for its transfer. Configuration writes are meant for idle
// periods only.
`default_nettype none
module trajectory_tracking_velocity_controller #(
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 18
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [ttvc_pkg::CFG_IW-1:0] cfg_idx,
	input  wire logic [ttvc_pkg::CFG_DW-1:0] cfg_wdata,
	ttvc_meas_if.sink                      meas,
	ttvc_cmd_if.source                     ctl
);
	import ttvc_pkg::*;

	cmd_t    cmd;
	status_t status;

	ttvc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(meas.valid),
		.in_ready(meas.ready),
		.status  (status),
		.cmd     (cmd)
	);

	ttvc_dp #(
		.FRAC_BITS   (FRAC_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.status      (status),
		.pos_x       (meas.pos_x),
		.pos_y       (meas.pos_y),
		.pos_z       (meas.pos_z),
		.heading     (meas.heading),
		.land_request(meas.land_request),
		.out_ready   (ctl.ready),
		.out_valid   (ctl.valid),
		.vel_x       (ctl.vel_x),
		.vel_y       (ctl.vel_y),
		.vel_z       (ctl.vel_z),
		.yaw_rate    (ctl.yaw_rate),
		.flight_phase(ctl.flight_phase),
		.err_x       (ctl.err_x),
		.err_y       (ctl.err_y),
		.err_z       (ctl.err_z),
		.err_yaw     (ctl.err_yaw)
	);

endmodule
`default_nettype wire
